@@ rtl/rotary_encoder_button_decoder_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the rotary encoder and button decoder
// Concurrent assertion wrappers. Defining ASSERT_OFF compiles them out.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_BUTTON_DECODER_TOP_DEFINES_SVH
`define ROTARY_ENCODER_BUTTON_DECODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked assertion, switched off while reset is held
`define REBD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: %m");

// Clocked assertion that also holds through reset
`define REBD_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("assertion failed: %m");

`else

`define REBD_ASSERT(name, clk, rst_n, prop)
`define REBD_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

@@ rtl/rebd_pkg.sv @@
// ----------------------------------------------------------------------------
// Rotary encoder and button decoder package
// Event codes, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package rebd_pkg;

    localparam int unsigned EVENT_W = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned THR_W = 3;
    localparam int unsigned CNT_W = 8;

    // Countdown value loaded on a button press
    localparam logic [CNT_W-1:0] PRESS_START = 8'hFF;

    typedef enum logic [EVENT_W-1:0] {
        EV_DEC      = 3'd0,
        EV_INC      = 3'd1,
        EV_HOLD_DEC = 3'd2,
        EV_HOLD_INC = 3'd3,
        EV_PUSH     = 3'd4,
        EV_HOLD     = 3'd5,
        EV_LONG     = 3'd6,
        EV_XLONG    = 3'd7
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DETENT_THR = 2'd0,
        CFG_HOLD       = 2'd1,
        CFG_LONG_HOLD  = 2'd2,
        CFG_XLONG_HOLD = 2'd3
    } t_cfg_idx;

    // Countdown value at which a set point of the given tick count is met
    function automatic logic [CNT_W-1:0] set_point(input logic [CNT_W-1:0] ticks);
        set_point = PRESS_START - ticks;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rotary_encoder_button_decoder_top.sv @@
// ----------------------------------------------------------------------------
// Rotary encoder and pushbutton decoder
// Decodes encoder pin samples and 20 ms ticks into rotation and button events.
// ----------------------------------------------------------------------------
// Each request is a pin sample or a timer tick. Requests enter an input
// register, the event logic updates the position count, the press countdown
// and the previous pins in one pass, and a result register holds the event
// until it is taken. One request is accepted every clock; the input side
// stalls only while the result register is full and stalled. A request gives
// at most one event: rotation events at a detent, push on a short press,
// hold, long hold and extra long hold on ticks. Users write the four config
// registers only with no request in flight; the block does not enforce it.
`default_nettype none

`include "rotary_encoder_button_decoder_top_defines.svh"

module rotary_encoder_button_decoder_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [rebd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rebd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_cmd,
    input  wire logic                             i_enc_a,
    input  wire logic                             i_enc_b,
    input  wire logic                             i_button_level,
    // event channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [rebd_pkg::EVENT_W-1:0]          o_event_res
);
    import rebd_pkg::*;

    // configuration registers
    logic [THR_W-1:0] r_detent_thr;
    logic [CNT_W-1:0] r_hold_ticks;
    logic [CNT_W-1:0] r_long_ticks;
    logic [CNT_W-1:0] r_xlong_ticks;

    // input register
    logic r_s1_valid;
    logic r_s1_cmd;
    logic r_s1_a;
    logic r_s1_b;
    logic r_s1_btn;

    // decoder state
    logic             r_prev_btn;
    logic             r_prev_a;
    logic             r_prev_b;
    logic [CNT_W-1:0] r_position;
    logic [CNT_W-1:0] r_countdown;
    logic             n_prev_btn;
    logic             n_prev_a;
    logic             n_prev_b;
    logic [CNT_W-1:0] n_position;
    logic [CNT_W-1:0] n_countdown;

    // result register
    logic   r_out_valid;
    t_event r_event;
    logic   n_have;
    t_event n_event;

    logic in_accept;
    logic s1_adv;
    logic s1_fire;

    // decode helpers
    logic              enc_change;
    logic              detent;
    logic              btn_change;
    logic [CNT_W-1:0]  pos_step;
    logic signed [CNT_W:0] pos_ext;
    logic signed [CNT_W:0] thr_ext;
    logic [CNT_W-1:0]  cd_dec;

    // handshake
    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && s1_adv;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_event;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detent_thr  <= 3'd2;
            r_hold_ticks  <= 8'd60;
            r_long_ticks  <= 8'd120;
            r_xlong_ticks <= 8'd254;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DETENT_THR: r_detent_thr  <= i_cfg_data[THR_W-1:0];
                CFG_HOLD:       r_hold_ticks  <= i_cfg_data;
                CFG_LONG_HOLD:  r_long_ticks  <= i_cfg_data;
                CFG_XLONG_HOLD: r_xlong_ticks <= i_cfg_data;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd <= i_cmd;
            r_s1_a   <= i_enc_a;
            r_s1_b   <= i_enc_b;
            r_s1_btn <= i_button_level;
        end
    end

    // pin change detection and count step
    assign enc_change = (r_s1_a ^ r_prev_a) | (r_s1_b ^ r_prev_b);
    assign detent     = r_s1_a & r_s1_b;
    assign btn_change = r_s1_btn ^ r_prev_btn;
    assign pos_step   = (r_prev_a != r_s1_b) ? r_position + 8'd1 : r_position - 8'd1;
    assign pos_ext    = $signed({pos_step[CNT_W-1], pos_step});
    assign thr_ext    = $signed({{(CNT_W + 1 - THR_W){1'b0}}, r_detent_thr});
    assign cd_dec     = r_countdown - 8'd1;

    // event logic, one request per pass
    always_comb begin
        n_prev_btn  = r_prev_btn;
        n_prev_a    = r_prev_a;
        n_prev_b    = r_prev_b;
        n_position  = r_position;
        n_countdown = r_countdown;
        n_have      = 1'b0;
        n_event     = EV_DEC;
        if (r_s1_cmd) begin
            // timer tick: later set points win
            if (r_countdown != '0) begin
                n_countdown = cd_dec;
                if (cd_dec == set_point(r_hold_ticks)) begin
                    n_have  = 1'b1;
                    n_event = EV_HOLD;
                end
                if (cd_dec == set_point(r_long_ticks)) begin
                    n_have  = 1'b1;
                    n_event = EV_LONG;
                end
                if (cd_dec == set_point(r_xlong_ticks)) begin
                    n_have  = 1'b1;
                    n_event = EV_XLONG;
                end
            end
        end else begin
            // encoder step and detent check
            if (enc_change) begin
                n_position = pos_step;
                if (detent) begin
                    if (!r_s1_btn) begin
                        n_countdown = '0;
                    end
                    if (pos_ext > thr_ext) begin
                        n_have  = 1'b1;
                        n_event = r_s1_btn ? EV_DEC : EV_HOLD_DEC;
                    end
                    if (pos_ext < -thr_ext) begin
                        n_have  = 1'b1;
                        n_event = r_s1_btn ? EV_INC : EV_HOLD_INC;
                    end
                    n_position = '0;
                end
            end
            // button edge; a push overrides an encoder event
            if (btn_change) begin
                if (r_s1_btn) begin
                    if (r_countdown > set_point(r_hold_ticks)) begin
                        n_have  = 1'b1;
                        n_event = EV_PUSH;
                    end
                    n_countdown = '0;
                end else begin
                    n_countdown = PRESS_START;
                end
            end
            n_prev_btn = r_s1_btn;
            n_prev_a   = r_s1_a;
            n_prev_b   = r_s1_b;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_btn  <= 1'b1;
            r_prev_a    <= 1'b1;
            r_prev_b    <= 1'b1;
            r_position  <= '0;
            r_countdown <= '0;
        end else if (s1_fire) begin
            r_prev_btn  <= n_prev_btn;
            r_prev_a    <= n_prev_a;
            r_prev_b    <= n_prev_b;
            r_position  <= n_position;
            r_countdown <= n_countdown;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= n_have;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && n_have) begin
            r_event <= n_event;
        end
    end

    // checks
    `REBD_ASSERT(a_stall_when_full, i_clk, i_rst_n,
        (r_s1_valid && r_out_valid && i_out_stall) |-> o_in_stall)
    `REBD_ASSERT(a_detent_clears_pos, i_clk, i_rst_n,
        (s1_fire && !r_s1_cmd && enc_change && detent) |=> (r_position == '0))
    `REBD_ASSERT(a_idle_tick_quiet, i_clk, i_rst_n,
        (s1_fire && r_s1_cmd && r_countdown == '0) |=> ($stable(r_countdown) && !o_out_valid))
    `REBD_ASSERT(a_release_clears_cd, i_clk, i_rst_n,
        (s1_fire && !r_s1_cmd && btn_change && r_s1_btn) |=> (r_countdown == '0))
    `REBD_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> (!r_s1_valid && !o_out_valid))

endmodule

`default_nettype wire

@@ sim/rotary_encoder_button_decoder_top_test.sv @@
// ----------------------------------------------------------------------------
// Rotary encoder and button decoder testbench
// Drives pin samples and ticks with random idling on both channels, predicts
// every event in step with the accepted requests and checks the event stream.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_button_decoder_top_test;

    import rebd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic cmd;
        logic enc_a;
        logic enc_b;
        logic button_level;
    } t_request;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    // DUT connections, the inputs all known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_cmd = 1'b0;
    logic                  i_enc_a = 1'b1;
    logic                  i_enc_b = 1'b1;
    logic                  i_button_level = 1'b1;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [EVENT_W-1:0]    o_event_res;

    // Request queue for the driver, events still owed by the block
    t_request pending_requests[$];
    t_event   expected_events[$];

    int  fail_count = 0;
    int  quiet_cycles = 0;
    bit  in_fire = 1'b0;

    t_idle_mode idle_mode = IDLE_NONE;
    int         mode_left = 0;

    // Predicted decoder state and registers
    logic [THR_W-1:0]        thr_reg;
    logic [CNT_W-1:0]        hold_reg;
    logic [CNT_W-1:0]        long_reg;
    logic [CNT_W-1:0]        xlong_reg;
    logic [2:0]              prev_pins;
    logic signed [CNT_W-1:0] position_count;
    logic [CNT_W-1:0]        press_countdown;

    // Stimulus side: pin levels as last queued and register values as written
    bit gen_a = 1'b1;
    bit gen_b = 1'b1;
    bit gen_btn = 1'b1;
    int set_hold = 60;
    int set_long = 120;
    int set_xlong = 254;
    int items_made = 0;

    rotary_encoder_button_decoder_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_enc_a        (i_enc_a),
        .i_enc_b        (i_enc_b),
        .i_button_level (i_button_level),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_res    (o_event_res)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Event that the decoder owes for one request, if any; updates the state
    function automatic bit predict_event(input t_request req, output t_event ev);
        logic [2:0] pins;
        logic [2:0] diff;
        int         pos;
        bit         have;
        have = 1'b0;
        ev = EV_DEC;
        if (req.cmd) begin
            // tick: count a running press down and look for the set points
            if (press_countdown != '0) begin
                press_countdown = press_countdown - 8'd1;
                if (press_countdown == 8'hFF - hold_reg) begin
                    ev = EV_HOLD;
                    have = 1'b1;
                end
                if (press_countdown == 8'hFF - long_reg) begin
                    ev = EV_LONG;
                    have = 1'b1;
                end
                if (press_countdown == 8'hFF - xlong_reg) begin
                    ev = EV_XLONG;
                    have = 1'b1;
                end
            end
        end else begin
            pins = {req.enc_b, req.enc_a, req.button_level};
            diff = pins ^ prev_pins;
            // encoder step, then detent evaluation with both channels high
            if (diff[2:1] != 2'b00) begin
                if (prev_pins[1] != pins[2])
                    position_count = position_count + 8'sd1;
                else
                    position_count = position_count - 8'sd1;
                if (pins[2:1] == 2'b11) begin
                    pos = position_count;
                    if (!pins[0])
                        press_countdown = '0;
                    if (pos > int'(thr_reg)) begin
                        ev = pins[0] ? EV_DEC : EV_HOLD_DEC;
                        have = 1'b1;
                    end
                    if (pos < -int'(thr_reg)) begin
                        ev = pins[0] ? EV_INC : EV_HOLD_INC;
                        have = 1'b1;
                    end
                    position_count = '0;
                end
            end
            // button edge; a push overrides any rotation event of this sample
            if (diff[0]) begin
                if (pins[0]) begin
                    if (press_countdown > 8'hFF - hold_reg) begin
                        ev = EV_PUSH;
                        have = 1'b1;
                    end
                    press_countdown = '0;
                end else begin
                    press_countdown = 8'hFF;
                end
            end
            prev_pins = pins;
        end
        return have;
    endfunction

    // Request driver: new request only once the previous one has gone
    always @(negedge i_clk) begin : request_driver
        t_request req;
        bit       hold_off;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                idle_mode = t_idle_mode'($urandom_range(3));
                mode_left = $urandom_range(60, 300);
            end else begin
                mode_left--;
            end
            hold_off = (idle_mode == IDLE_SENDER && $urandom_range(99) < 88) ||
                       (idle_mode == IDLE_BOTH && $urandom_range(99) < 27);
            if (!i_in_valid || in_fire) begin
                if (pending_requests.size() != 0 && !hold_off) begin
                    req = pending_requests.pop_front();
                    i_in_valid <= 1'b1;
                    i_cmd <= req.cmd;
                    i_enc_a <= req.enc_a;
                    i_enc_b <= req.enc_b;
                    i_button_level <= req.button_level;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= (idle_mode == IDLE_RECEIVER && $urandom_range(99) < 88) ||
                           (idle_mode == IDLE_BOTH && $urandom_range(99) < 27);
        end
    end

    // Monitor: register writes, accepted requests and accepted events
    always @(posedge i_clk) begin : event_monitor
        t_event   exp_ev;
        t_request req;
        if (!i_rst_n) begin
            in_fire = 1'b0;
            thr_reg = 3'd2;
            hold_reg = 8'd60;
            long_reg = 8'd120;
            xlong_reg = 8'd254;
            prev_pins = 3'b111;
            position_count = '0;
            press_countdown = '0;
        end else begin
            in_fire = i_in_valid && !o_in_stall;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DETENT_THR: thr_reg = i_cfg_data[THR_W-1:0];
                    CFG_HOLD:       hold_reg = i_cfg_data;
                    CFG_LONG_HOLD:  long_reg = i_cfg_data;
                    CFG_XLONG_HOLD: xlong_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("event %0d with none expected", o_event_res));
                end else begin
                    exp_ev = expected_events.pop_front();
                    if (o_event_res !== exp_ev)
                        report_mismatch($sformatf("event %0d, expected %0d",
                                                  o_event_res, exp_ev));
                end
            end
            if (in_fire) begin
                req = '{i_cmd, i_enc_a, i_enc_b, i_button_level};
                if (predict_event(req, exp_ev))
                    expected_events.push_back(exp_ev);
            end
        end
    end

    // Watchdog on cycles with no traffic on either channel
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** rotary_encoder_button_decoder_top: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_sample(input bit a, input bit b, input bit btn);
        t_request req;
        req = '{1'b0, a, b, btn};
        pending_requests.push_back(req);
        gen_a = a;
        gen_b = b;
        gen_btn = btn;
        items_made++;
    endtask

    // Tick with random pin fields, which the block ignores
    task automatic queue_tick();
        t_request req;
        req = '{1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1))};
        pending_requests.push_back(req);
        items_made++;
    endtask

    // One quadrature step along the Gray sequence 11, 01, 00, 10
    task automatic step_encoder(input int dir);
        int idx;
        case ({gen_a, gen_b})
            2'b11: idx = 0;
            2'b01: idx = 1;
            2'b00: idx = 2;
            default: idx = 3;
        endcase
        idx = (idx + dir + 4) % 4;
        queue_sample(idx == 0 || idx == 3, idx == 0 || idx == 1, gen_btn);
    endtask

    task automatic rotate(input int steps, input int dir);
        repeat (steps) step_encoder(dir);
    endtask

    // Press, tick to near a set point or up to 12 times, maybe turn the knob, release
    task automatic press_sequence();
        int ticks;
        int dir;
        case ($urandom_range(5))
            0: ticks = set_hold + $urandom_range(2) - 1;
            1: ticks = set_long + $urandom_range(2) - 1;
            2: ticks = set_xlong + $urandom_range(2) - 1;
            default: ticks = $urandom_range(12);
        endcase
        if (ticks < 0)
            ticks = 0;
        if (ticks > 260)
            ticks = 260;
        dir = $urandom_range(1) ? 1 : -1;
        queue_sample(gen_a, gen_b, 1'b0);
        repeat (ticks) begin
            queue_tick();
            if ($urandom_range(99) < 4)
                step_encoder(dir);
        end
        queue_sample(gen_a, gen_b, 1'b1);
    endtask

    // Wait for the block to go idle before touching the registers
    task automatic drain_pipeline();
        while (pending_requests.size() != 0 || i_in_valid || expected_events.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input int thr, input int hold, input int lng, input int xlng);
        drain_pipeline();
        write_reg(CFG_DETENT_THR, CFG_DATA_W'(thr));
        write_reg(CFG_HOLD, CFG_DATA_W'(hold));
        write_reg(CFG_LONG_HOLD, CFG_DATA_W'(lng));
        write_reg(CFG_XLONG_HOLD, CFG_DATA_W'(xlng));
        set_hold = hold;
        set_long = lng;
        set_xlong = xlng;
    endtask

    // Random traffic: mostly clean rotations and presses, some noise
    task automatic run_phase(input int count);
        int end_at;
        int kind;
        int dir;
        bit held;
        end_at = items_made + count;
        while (items_made < end_at) begin
            kind = $urandom_range(99);
            dir = $urandom_range(1) ? 1 : -1;
            if (kind < 35) begin
                held = ($urandom_range(99) < 30);
                if (held)
                    queue_sample(gen_a, gen_b, 1'b0);
                rotate($urandom_range(1, 10), dir);
                if (held)
                    queue_sample(gen_a, gen_b, 1'b1);
            end else if (kind < 70) begin
                press_sequence();
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(1))
                        queue_tick();
                    else
                        queue_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                                     1'($urandom_range(1)));
                end
            end else if (kind < 87) begin
                // both channels flipping at once keeps stepping one way
                repeat ($urandom_range(130, 280)) begin
                    if (gen_a)
                        queue_sample(1'b0, 1'b1, gen_btn);
                    else
                        queue_sample(1'b1, 1'b0, gen_btn);
                end
            end else begin
                // broken sequences: turn back half way, stray press or release
                rotate($urandom_range(1, 3), dir);
                rotate($urandom_range(1, 3), -dir);
                queue_sample(gen_a, gen_b, 1'($urandom_range(1)));
            end
        end
    endtask

    // Main sequence
    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset settings
        queue_tick();                       // tick with no press running
        queue_sample(1'b1, 1'b1, 1'b1);     // no change at all
        rotate(4, 1);                       // one detent each way
        rotate(4, -1);
        queue_sample(1'b1, 1'b1, 1'b0);     // detent while held
        rotate(4, 1);
        queue_sample(1'b1, 1'b1, 1'b1);     // release after a held turn
        queue_sample(1'b1, 1'b1, 1'b0);     // short press gives a push
        queue_tick();
        queue_sample(1'b1, 1'b1, 1'b1);
        queue_sample(1'b1, 1'b1, 1'b0);     // detent and release in one sample
        rotate(3, 1);
        queue_sample(1'b1, 1'b1, 1'b1);
        queue_tick();
        run_phase(150);

        set_config(0, 1, 2, 3);
        run_phase(150);
        set_config(7, 0, 255, 254);
        run_phase(150);
        set_config(3, 255, 8, 8);
        run_phase(150);
        set_config($urandom_range(7), $urandom_range(1, 30), $urandom_range(1, 40),
                   $urandom_range(1, 60));
        run_phase(150);
        set_config(1, 5, 5, 5);
        run_phase(150);
        set_config($urandom_range(7), $urandom_range(255), $urandom_range(255),
                   $urandom_range(255));
        run_phase(150);
        set_config(2, 60, 120, 254);
        run_phase(150);

        drain_pipeline();
        if (fail_count == 0)
            $display("** rotary_encoder_button_decoder_top: PASSED **");
        else
            $display("** rotary_encoder_button_decoder_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
